/* rtl/crf_pkg.sv */
// Package with shared constants for the continued-fraction rationalizer.
package crf_pkg;
  localparam int unsigned DataW       = 64;
  localparam int unsigned DenW        = 32;
  localparam int unsigned FracBitsDef = 32;
  localparam logic [DenW-1:0] MaxDenReset = 32'd1000000;
endpackage

/* rtl/crf_div.sv */
// Bit-serial restoring divider giving one quotient bit per cycle.
module crf_div #(
  parameter int unsigned QuoW = crf_pkg::FracBitsDef + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [crf_pkg::DataW-1:0]  dividend_i,
  input  logic [crf_pkg::DataW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [QuoW-1:0]            quo_o,
  output logic [crf_pkg::DataW-1:0]  rem_o
);
  localparam int unsigned CntW = $clog2(QuoW + 1);

  logic                      busy_q, busy_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [QuoW-1:0]           num_q, num_d;
  logic [QuoW-1:0]           quo_q, quo_d;
  logic [crf_pkg::DataW-1:0] rem_q, rem_d;
  logic [crf_pkg::DataW-1:0] den_q, den_d;
  logic [crf_pkg::DataW-1:0] rem_sh;
  logic                      fits;

  assign rem_sh = {rem_q[crf_pkg::DataW-2:0], num_q[QuoW-1]};
  assign fits   = rem_sh >= den_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(QuoW);
      num_d  = dividend_i[QuoW-1:0];
      den_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[QuoW-2:0], 1'b0};
      rem_d = fits ? (rem_sh - den_q) : rem_sh;
      quo_d = {quo_q[QuoW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o = quo_d;
  assign rem_o = rem_d;
endmodule

/* rtl/crf_mac.sv */
// Shift-and-add unit forming a*x1+x0 and a*y1+y0 over the bits of a.
module crf_mac #(
  parameter int unsigned MulW = crf_pkg::FracBitsDef + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [MulW-1:0]            a_i,
  input  logic [crf_pkg::DataW-1:0]  x1_i,
  input  logic [crf_pkg::DataW-1:0]  x0_i,
  input  logic [crf_pkg::DataW-1:0]  y1_i,
  input  logic [crf_pkg::DataW-1:0]  y0_i,
  output logic                       done_o,
  output logic [crf_pkg::DataW-1:0]  x_o,
  output logic [crf_pkg::DataW-1:0]  y_o
);
  logic                      busy_q;
  logic [MulW-1:0]           a_q;
  logic [crf_pkg::DataW-1:0] xs_q, ys_q, xa_q, ya_q;

  assign done_o = busy_q && (a_q == '0);
  assign x_o    = xa_q;
  assign y_o    = ya_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      xs_q <= x1_i;
      ys_q <= y1_i;
      xa_q <= x0_i;
      ya_q <= y0_i;
    end else if (busy_q && (a_q != '0)) begin
      a_q  <= a_q >> 1;
      xs_q <= xs_q << 1;
      ys_q <= ys_q << 1;
      if (a_q[0]) begin
        xa_q <= xa_q + xs_q;
        ya_q <= ya_q + ys_q;
      end
    end
  end
endmodule

/* rtl/continued_fraction_rationalizer.sv */
// Top level of the continued-fraction rationalizer with its step sequencer.
//
//  channel | signals                          | dir
//  cfg     | cfg_valid_i cfg_ready_o cfg_data_i | in
//  input   | in_valid_i in_ready_o value_i      | in
//  output  | out_valid_o out_ready_i numerator_o denominator_o | out
//
// Each Euclid step takes a check in the loop state, then a pass through the serial
// divider and a pass through the shift-and-add unit. The input is not ready
// while a word is being expanded. Reset loads the limit with one million. A
// stalled result holds in the output register until it is taken.
module continued_fraction_rationalizer #(
  parameter int unsigned FRAC_BITS = crf_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [crf_pkg::DenW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [crf_pkg::DataW-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [crf_pkg::DataW-1:0] numerator_o,
  output logic [crf_pkg::DenW-1:0]  denominator_o
);
  localparam int unsigned W  = crf_pkg::DataW;
  localparam int unsigned QW = FRAC_BITS + 1;

  typedef enum logic [2:0] {StIdle, StLoop, StDiv, StMac, StFin} state_e;

  state_e                   state_q;
  logic [crf_pkg::DenW-1:0] maxden_q, lim_q;
  logic                     neg_q;
  logic [W-1:0]             q_q, r_q, h_q, g_q, h1_q, h0_q, g1_q, g0_q;
  logic [W-1:0]             mag;
  logic                     div_start, div_done, mac_start, mac_done;
  logic [QW-1:0]            div_quo;
  logic [W-1:0]             div_rem, mac_x, mac_y;
  logic [W-1:0]             h_sel, g_sel;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign mag         = value_i[W-1] ? (W'(0) - W'(value_i)) : W'(value_i);
  assign div_start   = (state_q == StLoop) && (g_q <= W'(lim_q)) && (r_q != '0);
  assign mac_start   = (state_q == StDiv) && div_done;
  assign h_sel       = (g_q > W'(lim_q)) ? h1_q : h_q;
  assign g_sel       = (g_q > W'(lim_q)) ? g1_q : g_q;

  crf_div #(.QuoW(QW)) u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (q_q),
    .divisor_i  (r_q),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  crf_mac #(.MulW(QW)) u_mac (
    .clk_i, .rst_ni,
    .start_i (mac_start),
    .a_i     (div_quo),
    .x1_i    (h1_q),
    .x0_i    (h0_q),
    .y1_i    (g1_q),
    .y0_i    (g0_q),
    .done_o  (mac_done),
    .x_o     (mac_x),
    .y_o     (mac_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      maxden_q      <= crf_pkg::MaxDenReset;
      out_valid_o   <= 1'b0;
      numerator_o   <= '0;
      denominator_o <= '0;
    end else begin
      if (cfg_valid_i) begin
        maxden_q <= cfg_data_i;
      end
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StLoop;
          end
        end
        StLoop: begin
          state_q <= div_start ? StDiv : StFin;
        end
        StDiv: begin
          if (div_done) begin
            state_q <= StMac;
          end
        end
        StMac: begin
          if (mac_done) begin
            state_q <= StLoop;
          end
        end
        StFin: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o   <= 1'b1;
            numerator_o   <= neg_q ? (W'(0) - h_sel) : h_sel;
            denominator_o <= g_sel[crf_pkg::DenW-1:0];
            state_q       <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      neg_q <= value_i[W-1];
      lim_q <= (maxden_q == '0) ? crf_pkg::DenW'(1) : maxden_q;
      q_q   <= W'(1) << FRAC_BITS;
      r_q   <= mag & ((W'(1) << FRAC_BITS) - W'(1));
      h_q   <= mag >> FRAC_BITS;
      g_q   <= W'(1);
      h1_q  <= W'(1);
      h0_q  <= '0;
      g1_q  <= '0;
      g0_q  <= W'(1);
    end
    if (div_start) begin
      h0_q <= h1_q;
      h1_q <= h_q;
      g0_q <= g1_q;
      g1_q <= g_q;
    end
    if (mac_start) begin
      q_q <= r_q;
      r_q <= div_rem;
    end
    if (state_q == StMac && mac_done) begin
      h_q <= mac_x;
      g_q <= mac_y;
    end
  end
endmodule
